// ===== rtl/staf_pkg.sv =====
// Shared types and codes for the slot table allocate-and-find block.
package staf_pkg;

    // Operation selector carried on the input tuser
    typedef enum logic {
        FUNC_ALLOC  = 1'b0,
        FUNC_LOOKUP = 1'b1
    } t_func;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch request, clear scan accumulators
        logic scan;    // read one slot, advance address
        logic finish;  // load result register, commit allocation
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;  // address is on the last slot
        logic out_busy;   // result register holds a word not taken this cycle
    } t_dp_sts;

endpackage

// ===== rtl/staf_ctrl.sv =====
// Sequencer for the slot table: accept, walk all slots, drain, deliver.
module staf_ctrl
    import staf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DRAIN: begin
            end
            S_DONE: begin
                o_cmd.finish = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/staf_dp.sv =====
// Slot table datapath: id memory, occupied bits, scan accumulators, result register.
module staf_dp
    import staf_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_func,
    input  logic [15:0] i_lookup_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_status,
    output logic [3:0]  o_out_slot,
    output logic [15:0] o_out_id
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CMP_W = ID_BITS + 16;
    localparam int SLT_W = IDX_W + 4;

    // Request
    logic               r_func;
    logic [15:0]        r_lookup;

    // Table storage
    logic [ID_BITS-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_occ;

    // Scan read pipe
    logic [IDX_W-1:0]   r_addr;
    logic               r_rd_vld;
    logic               r_rd_occ;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [ID_BITS-1:0] r_rd_data;

    // Accumulators
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [ID_BITS-1:0] r_top;
    logic               r_match_found;
    logic [IDX_W-1:0]   r_match_idx;

    // Result register
    logic               r_out_vld;
    t_status            r_out_status;
    logic [3:0]         r_out_slot;
    logic [15:0]        r_out_id;

    t_status            n_status;
    logic [IDX_W-1:0]   n_slot;
    logic [ID_BITS-1:0] n_id;
    logic               n_commit;

    logic [ID_BITS-1:0] w_next_id;
    logic               w_hit;
    logic [SLT_W-1:0]   w_slot_ext;
    logic [CMP_W-1:0]   w_id_ext;

    assign w_next_id = r_top + ID_BITS'(1);
    assign w_hit     = r_rd_occ && (CMP_W'(r_rd_data) == CMP_W'(r_lookup));

    always_comb begin
        n_status = ST_OK;
        n_slot   = '0;
        n_id     = '0;
        n_commit = 1'b0;
        if (r_func == FUNC_ALLOC) begin
            priority if (!r_free_found) begin
                n_status = ST_FULL;
            end else if (r_top == '1) begin
                n_status = ST_EXHAUSTED;
            end else begin
                n_slot   = r_free_idx;
                n_id     = w_next_id;
                n_commit = 1'b1;
            end
        end else begin
            if (r_match_found) begin
                n_slot = r_match_idx;
                n_id   = ID_BITS'(r_lookup);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    // Fields are masked to their port widths
    assign w_slot_ext = SLT_W'(n_slot);
    assign w_id_ext   = CMP_W'(n_id);

    // Memory: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && n_commit) r_mem[r_free_idx] <= w_next_id;
        if (i_cmd.scan) r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.finish && n_commit) r_occ[r_free_idx] <= 1'b1;
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func        <= i_func;
            r_lookup      <= i_lookup_id;
            r_addr        <= '0;
            r_free_found  <= 1'b0;
            r_free_idx    <= '0;
            r_top         <= '0;
            r_match_found <= 1'b0;
            r_match_idx   <= '0;
        end else begin
            if (i_cmd.scan) begin
                r_addr   <= r_addr + IDX_W'(1);
                r_rd_occ <= r_occ[r_addr];
                r_rd_idx <= r_addr;
            end
            if (r_rd_vld) begin
                if (!r_rd_occ) begin
                    if (!r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_rd_idx;
                    end
                end else if (r_rd_data > r_top) begin
                    r_top <= r_rd_data;
                end
                if (w_hit && !r_match_found) begin
                    r_match_found <= 1'b1;
                    r_match_idx   <= r_rd_idx;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_slot   <= w_slot_ext[3:0];
            r_out_id     <= w_id_ext[15:0];
        end
    end

    assign o_sts.scan_last = (r_addr == IDX_W'(ENTRIES - 1));
    assign o_sts.out_busy  = r_out_vld && !i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;
    assign o_out_id     = r_out_id;

endmodule

// ===== rtl/slot_table_allocate_and_find.sv =====
// Top level of the slot table allocator with lookup by id.
//
// A table of ENTRIES slots, each with an occupied bit and an ID_BITS-wide id.
// Reset frees every slot. An allocate word (tuser 0) takes the lowest free
// slot and tags it with one above the largest id held by any occupied slot
// (1 when the table is empty); it answers table full when no slot is free,
// or id range exhausted when the new id would not fit in ID_BITS. A lookup
// word (tuser 1) answers the lowest occupied slot whose id equals tdata, or
// not found. Every input word gives exactly one output word. The block works
// on one request at a time: it accepts the word, reads one slot per cycle from
// the id memory, folds the last read, then loads the result and writes back;
// it waits before the load only while the previous result has still not been
// taken. The result sits in an output register, so the next request is
// accepted while that result waits.
module slot_table_allocate_and_find
    import staf_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] lookup_id
    input  logic [0:0]  s_axis_tuser,   // [0] func
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [3:0] slot_index, [19:4] assigned_id, [23:20] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [3:0]  w_slot;
    logic [15:0] w_id;

    staf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    staf_dp #(
        .ENTRIES (ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_func       (s_axis_tuser[0]),
        .i_lookup_id  (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_slot   (w_slot),
        .o_out_id     (w_id)
    );

    assign m_axis_tdata = {4'b0000, w_id, w_slot};

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.finish && w_sts.out_busy))
        else $error("result loaded while output still pending");

    // Load, scan and finish are distinct phases
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.scan, w_cmd.finish}))
        else $error("overlapping datapath commands");

    // After accepting a request the block is busy for the walk
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted during a walk");

    // Failed requests carry zero slot and id
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == 24'd0))
        else $error("nonzero payload on failed request");

endmodule

// ===== tb/sv/slot_table_allocate_and_find_tb.sv =====
// Self-checking testbench for the slot table allocate-and-find block.
`timescale 1ns / 1ps

module slot_table_allocate_and_find_tb;
    import staf_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int ID_BITS     = 16;
    localparam int LATENCY     = ENTRIES + 3;
    localparam int N_RANDOM    = 1800;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_AT     = 400;           // words accepted before the long receiver hold
    localparam int HOLD_CYCLES = 300;

    // One result word, split into its fields
    typedef struct packed {
        t_status     status;
        logic [3:0]  slot_index;
        logic [15:0] assigned_id;
    } t_result;

    // One row of the directed table; known marks a result typed in by hand
    typedef struct packed {
        t_func       func;
        logic [15:0] lookup_id;
        logic        known;
        t_result     exp;
    } t_row;

    localparam t_result NONE = '{ST_OK, 4'd0, 16'd0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] lookup_id
    logic [0:0]  s_axis_tuser = '0;     // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [3:0] slot_index, [19:4] assigned_id, [23:20] zero
    logic [1:0]  m_axis_tuser;          // [1:0] status

    // Shadow copy of the slot table
    logic        occ_model [ENTRIES];
    logic [31:0] id_model  [ENTRIES];

    t_result pending_results [$];
    int      words_sent  = 0;
    int      fail_count  = 0;
    int      cycle_count = 0;
    logic    hold_done   = 1'b0;
    logic    idle_on;

    // Random idling everywhere except one quiet stretch in the middle
    assign idle_on = (words_sent < 900) || (words_sent >= 1200);

    slot_table_allocate_and_find #(
        .ENTRIES(ENTRIES),
        .ID_BITS(ID_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the answer
    function automatic t_result alloc_or_find(t_func f, logic [15:0] want);
        t_result r;
        int      free_slot;
        logic [31:0] top;
        logic [32:0] next_id;
        r = '{ST_NOT_FOUND, 4'd0, 16'd0};
        free_slot = -1;
        top = '0;
        if (f == FUNC_ALLOC) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!occ_model[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (id_model[i] > top) begin
                    top = id_model[i];
                end
            end
            next_id = {1'b0, top} + 33'd1;
            if (free_slot < 0) begin
                r.status = ST_FULL;
            end else if (next_id > ((33'd1 << ID_BITS) - 33'd1)) begin
                // only reachable once ids climb to the top of the range
                r.status = ST_EXHAUSTED;
            end else begin
                occ_model[free_slot] = 1'b1;
                id_model[free_slot]  = next_id[31:0];
                r = '{ST_OK, free_slot[3:0], next_id[15:0]};
            end
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                // walk down so the lowest matching slot wins
                if (occ_model[i] && id_model[i] == {16'd0, want})
                    r = '{ST_OK, i[3:0], id_model[i][15:0]};
            end
        end
        return r;
    endfunction

    // Offers one request word and waits for it to be taken
    task automatic send_word(t_func f, logic [15:0] want, logic known, t_result typed);
        t_result r;
        if (idle_on) begin
            while ($urandom_range(99) < 33) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= want;
        s_axis_tuser  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        r = alloc_or_find(f, want);
        pending_results.push_back(known ? typed : r);
        words_sent++;
    endtask

    // Stimulus: reset, directed table, random requests, drain
    initial begin
        t_row  dir_rows [24];
        t_func f;
        logic [15:0] want;
        dir_rows = '{
            '{FUNC_LOOKUP, 16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 16'd0}},  // empty table
            '{FUNC_LOOKUP, 16'hFFFF, 1'b1, '{ST_NOT_FOUND, 4'd0, 16'd0}},
            '{FUNC_ALLOC,  16'hFFFF, 1'b1, '{ST_OK, 4'd0, 16'd1}},         // first id is 1
            '{FUNC_LOOKUP, 16'h0001, 1'b1, '{ST_OK, 4'd0, 16'd1}},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},
            '{FUNC_ALLOC,  16'h0000, 1'b0, NONE},                          // last free slot
            '{FUNC_ALLOC,  16'h0000, 1'b1, '{ST_FULL, 4'd0, 16'd0}},       // table full
            '{FUNC_LOOKUP, 16'h0010, 1'b1, '{ST_OK, 4'd15, 16'd16}},
            '{FUNC_LOOKUP, 16'h0011, 1'b1, '{ST_NOT_FOUND, 4'd0, 16'd0}},
            '{FUNC_LOOKUP, 16'h0000, 1'b1, '{ST_NOT_FOUND, 4'd0, 16'd0}},  // id 0 never held
            '{FUNC_LOOKUP, 16'h8008, 1'b0, NONE}
        };
        for (int i = 0; i < ENTRIES; i++) begin
            occ_model[i] = 1'b0;
            id_model[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].func, dir_rows[i].lookup_id, dir_rows[i].known,
                      dir_rows[i].exp);

        // mostly lookups near the live ids, some wide ids, some allocates
        for (int n = 0; n < N_RANDOM; n++) begin
            f = ($urandom_range(99) < 15) ? FUNC_ALLOC : FUNC_LOOKUP;
            want = ($urandom_range(99) < 60) ? 16'($urandom_range(0, ENTRIES + 1))
                                             : 16'($urandom_range(0, 65535));
            send_word(f, want, 1'b0, NONE);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Result side: random back-pressure, one long hold to fill the block
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on) begin
                m_axis_tready <= ($urandom_range(99) >= 33);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d data %h", m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[3:0] !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", want.slot_index,
                           m_axis_tdata[3:0]);
                    fail_count++;
                end
                if (m_axis_tdata[19:4] !== want.assigned_id) begin
                    $error("assigned_id: expected %0d, got %0d", want.assigned_id,
                           m_axis_tdata[19:4]);
                    fail_count++;
                end
                if (m_axis_tdata[23:20] !== 4'd0) begin
                    $error("pad: expected 0, got %0d", m_axis_tdata[23:20]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
